// ===== rtl/core/stirling_bell_number_engine_core_assert.svh =====
// assertion macros for the stirling / bell number engine
// used by the controller; no other dependencies
`ifndef STIRLING_BELL_NUMBER_ENGINE_CORE_ASSERT_SVH
`define STIRLING_BELL_NUMBER_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SBN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sbn assertion failed");
`define SBN_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sbn assertion failed");
`else
`define SBN_ASSERT(lbl, clk, rst, prop)
`define SBN_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/sbn_pkg.sv =====
// shared constants, state enum and command struct for the stirling / bell engine
// no dependencies
package sbn_pkg;

  localparam int AddrW = 5;
  localparam int DataW = 64;
  localparam int RowDepth = 26;
  localparam logic [AddrW-1:0] MaxN = AddrW'(25);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_INIT,
    ST_PRIME,
    ST_STEP,
    ST_SUM,
    ST_SUM_LAST,
    ST_REPORT
  } sbn_state_t;

  typedef struct packed {
    logic             wr_en;
    logic             wr_one;
    logic [AddrW-1:0] wr_addr;
    logic [AddrW-1:0] rd_addr;
    logic             mul_en;
    logic [AddrW-1:0] mul_factor;
    logic             acc_clr;
    logic             acc_en;
    logic             cap_en;
    logic             out_en;
    logic             out_err;
  } sbn_cmd_t;

endpackage

// ===== rtl/core/sbn_dpath.sv =====
// datapath: row store, multiply stage, row adder, bell accumulator, result registers
// depends on sbn_pkg
module sbn_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  sbn_pkg::sbn_cmd_t             cmd,
  output logic                          done,
  output logic [sbn_pkg::DataW-1:0]     stirling_value,
  output logic [sbn_pkg::DataW-1:0]     bell_value,
  output logic                          range_error
);
  import sbn_pkg::*;

  logic [DataW-1:0] row_mem [RowDepth];
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] prod;
  logic [DataW-1:0] acc;
  logic [DataW-1:0] stir;
  logic [DataW-1:0] wr_data;

  assign wr_data = cmd.wr_one ? DataW'(1) : rd_data + prod;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      row_mem[cmd.wr_addr] <= wr_data;
    end
    rd_data <= row_mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= DataW'(rd_data * cmd.mul_factor);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + rd_data;
    end
    if (cmd.cap_en) begin
      stir <= rd_data;
    end
    if (cmd.out_en) begin
      stirling_value <= cmd.out_err ? '0 : stir;
      bell_value     <= cmd.out_err ? '0 : acc;
      range_error    <= cmd.out_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_en;
    end
  end

endmodule

// ===== rtl/core/sbn_ctrl.sv =====
// controller: request check, row / column / sum sequencing, datapath commands
// depends on sbn_pkg and stirling_bell_number_engine_core_assert.svh
`include "stirling_bell_number_engine_core_assert.svh"

module sbn_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [4:0]                    set_size,
  input  logic [4:0]                    part_count,
  output logic                          busy,
  output sbn_pkg::sbn_cmd_t             cmd
);
  import sbn_pkg::*;

  sbn_state_t state, state_next;
  logic [AddrW-1:0] n_reg, n_next;
  logic [AddrW-1:0] k_reg, k_next;
  logic             err_reg, err_next;
  logic [AddrW-1:0] row, row_next;
  logic [AddrW-1:0] col, col_next;
  logic [AddrW-1:0] sum_addr, sum_addr_next;
  logic             sum_pend;
  logic             sum_hit;
  logic             req_err;

  assign req_err = (set_size == '0) || (set_size > MaxN) ||
                   (part_count == '0) || (part_count > set_size);
  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    n_next        = n_reg;
    k_next        = k_reg;
    err_next      = err_reg;
    row_next      = row;
    col_next      = col;
    sum_addr_next = sum_addr;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          n_next     = set_size;
          k_next     = part_count;
          err_next   = req_err;
          row_next   = AddrW'(1);
          state_next = req_err ? ST_REPORT : ST_ROW_INIT;
        end
      end
      ST_ROW_INIT: begin
        if (row >= AddrW'(3)) begin
          col_next   = row - AddrW'(1);
          state_next = ST_PRIME;
        end else if (row == n_reg) begin
          sum_addr_next = AddrW'(1);
          state_next    = ST_SUM;
        end else begin
          row_next = row + AddrW'(1);
        end
      end
      ST_PRIME: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        col_next = col - AddrW'(1);
        if (col == AddrW'(2)) begin
          if (row == n_reg) begin
            sum_addr_next = AddrW'(1);
            state_next    = ST_SUM;
          end else begin
            row_next   = row + AddrW'(1);
            state_next = ST_ROW_INIT;
          end
        end
      end
      ST_SUM: begin
        sum_addr_next = sum_addr + AddrW'(1);
        if (sum_addr == n_reg) begin
          state_next = ST_SUM_LAST;
        end
      end
      ST_SUM_LAST: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.acc_en = sum_pend;
    cmd.cap_en = sum_hit;
    unique case (state)
      ST_IDLE: begin
        cmd.acc_clr = 1'b1;
      end
      ST_ROW_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_one  = 1'b1;
        cmd.wr_addr = row;
        cmd.rd_addr = row - AddrW'(1);
      end
      ST_PRIME: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_factor = col;
        cmd.rd_addr    = col - AddrW'(1);
      end
      ST_STEP: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_addr    = col;
        cmd.mul_en     = 1'b1;
        cmd.mul_factor = col - AddrW'(1);
        cmd.rd_addr    = col - AddrW'(2);
      end
      ST_SUM: begin
        cmd.rd_addr = sum_addr;
      end
      ST_SUM_LAST: begin
        cmd.rd_addr = sum_addr;
      end
      ST_REPORT: begin
        cmd.out_en  = 1'b1;
        cmd.out_err = err_reg;
      end
      default: begin
        cmd.acc_clr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sum_pend <= 1'b0;
      sum_hit  <= 1'b0;
    end else begin
      state    <= state_next;
      sum_pend <= (state == ST_SUM);
      sum_hit  <= (state == ST_SUM) && (sum_addr == k_reg);
    end
  end

  always_ff @(posedge clk) begin
    n_reg    <= n_next;
    k_reg    <= k_next;
    err_reg  <= err_next;
    row      <= row_next;
    col      <= col_next;
    sum_addr <= sum_addr_next;
  end

  `SBN_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `SBN_ASSERT(a_wr_range, clk, rst, cmd.wr_en |-> (cmd.wr_addr != '0 && cmd.wr_addr <= MaxN))
  `SBN_ASSERT(a_sum_no_wr, clk, rst, cmd.acc_en |-> !cmd.wr_en)
  `SBN_ASSERT(a_step_col, clk, rst, (state == ST_STEP) |-> (col >= AddrW'(2)))
  `SBN_ASSERT(a_report_idle, clk, rst, cmd.out_en |=> (state == ST_IDLE))

endmodule

// ===== rtl/core/stirling_bell_number_engine_core.sv =====
// top level of the stirling / bell number engine: controller plus datapath
// depends on sbn_pkg, sbn_ctrl, sbn_dpath
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  request  | start, busy         | set_size, part_count
//  result   | done (one cycle)    | stirling_value, bell_value, range_error
//
// an item is taken when start is high and busy is low; one result per item
// valid item: the row store is built row by row (ST_ROW_INIT, then ST_PRIME and
//   ST_STEP from row 3 on; one multiply-add per ST_STEP cycle, one read and one
//   write of the row store), then ST_SUM, ST_SUM_LAST and ST_REPORT
// out-of-range item: goes straight to ST_REPORT; done is registered from that state
// rst is synchronous; row store contents are not cleared and need not be
// results cannot be held off; a new item may be taken in the cycle done is high
module stirling_bell_number_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [4:0]  set_size,
  input  logic [4:0]  part_count,
  output logic        busy,
  output logic        done,
  output logic [63:0] stirling_value,
  output logic [63:0] bell_value,
  output logic        range_error
);
  import sbn_pkg::*;

  sbn_cmd_t cmd;

  sbn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .set_size   (set_size),
    .part_count (part_count),
    .busy       (busy),
    .cmd        (cmd)
  );

  sbn_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .done           (done),
    .stirling_value (stirling_value),
    .bell_value     (bell_value),
    .range_error    (range_error)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for stirling_bell_number_engine_core: S(n,k), bell number, range flag
// depends on sbn_pkg and the engine rtl; a scoreboard class predicts each item and checks it
// directed corner items first, then random valid, out-of-range and noise items with random gaps
module testbench;
  import sbn_pkg::*;

  localparam int HalfPeriod = 4;
  localparam int ResetCycles = 12;
  localparam int RandomItems = 400;
  localparam int QuietLimit = 4000;
  localparam int DrainCycles = 10;

  class partition_scoreboard;
    typedef struct packed {
      bit [DataW-1:0] stirling;
      bit [DataW-1:0] bell;
      bit             range_error;
    } partition_counts_t;

    bit [DataW-1:0]    row_cells [RowDepth];
    partition_counts_t pending_counts[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       out_of_range;
    int unsigned       results;

    function partition_counts_t count_partitions(logic [AddrW-1:0] n, logic [AddrW-1:0] k);
      partition_counts_t c;
      int unsigned i;
      int unsigned j;
      c = '0;
      if (n == 0 || n > MaxN || k == 0 || k > n) begin
        c.range_error = 1'b1;
        return c;
      end
      for (i = 1; i <= n; i++) begin
        row_cells[i] = 1;
        for (j = i - 1; j > 1; j--)
          row_cells[j] = row_cells[j-1] + DataW'(j) * row_cells[j];
      end
      for (i = 1; i <= n; i++)
        c.bell += row_cells[i];
      c.stirling = row_cells[k];
      return c;
    endfunction

    function void note_request(logic [AddrW-1:0] n, logic [AddrW-1:0] k);
      partition_counts_t c;
      c = count_partitions(n, k);
      requests++;
      if (c.range_error)
        out_of_range++;
      pending_counts.push_back(c);
    endfunction

    function void check_result(logic [DataW-1:0] stirling, logic [DataW-1:0] bell,
                               logic range_error);
      partition_counts_t c;
      results++;
      if (pending_counts.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: stirling %0d bell %0d range_error %0b",
                 $time, stirling, bell, range_error);
        return;
      end
      c = pending_counts.pop_front();
      if (stirling !== c.stirling) begin
        errors++;
        $display("%0t: stirling_value expected %0d actual %0d", $time, c.stirling, stirling);
      end
      if (bell !== c.bell) begin
        errors++;
        $display("%0t: bell_value expected %0d actual %0d", $time, c.bell, bell);
      end
      if (range_error !== c.range_error) begin
        errors++;
        $display("%0t: range_error expected %0b actual %0b", $time, c.range_error,
                 range_error);
      end
    endfunction

    function int unsigned pending();
      return pending_counts.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [AddrW-1:0] set_size = '0;
  logic [AddrW-1:0] part_count = '0;
  logic             busy;
  logic             done;
  logic [DataW-1:0] stirling_value;
  logic [DataW-1:0] bell_value;
  logic             range_error;

  partition_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;

  stirling_bell_number_engine_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .set_size       (set_size),
    .part_count     (part_count),
    .busy           (busy),
    .done           (done),
    .stirling_value (stirling_value),
    .bell_value     (bell_value),
    .range_error    (range_error)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy)
        sb.note_request(set_size, part_count);
      if (done)
        sb.check_result(stirling_value, bell_value, range_error);
      if ((start && !busy) || done)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue_item(input logic [AddrW-1:0] n, input logic [AddrW-1:0] k,
                            input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      set_size <= AddrW'($urandom);
      part_count <= AddrW'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    set_size <= n;
    part_count <= k;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  task automatic issue_random_item();
    int unsigned mode;
    int unsigned n;
    mode = $urandom_range(0, 99);
    n = $urandom_range(1, MaxN);
    if (mode < 70)
      issue_item(AddrW'(n), AddrW'($urandom_range(1, n)), pick_gap());
    else if (mode < 80)
      issue_item(AddrW'(n), AddrW'($urandom_range(n + 1, 31)), pick_gap());
    else if (mode < 85)
      issue_item(AddrW'(n), '0, pick_gap());
    else
      issue_item(AddrW'($urandom), AddrW'($urandom), pick_gap());
  endtask

  initial begin
    while (quiet_cycles < QuietLimit)
      @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners: empty set, zero parts, too many parts, largest sizes, set too large
    issue_item(5'd1, 5'd1, 0);
    issue_item(5'd0, 5'd0, 0);
    issue_item(5'd0, 5'd1, 1);
    issue_item(5'd1, 5'd0, 0);
    issue_item(5'd1, 5'd2, 0);
    issue_item(5'd2, 5'd1, 2);
    issue_item(5'd2, 5'd2, 0);
    issue_item(5'd3, 5'd2, 0);
    issue_item(5'd25, 5'd1, 0);
    issue_item(5'd25, 5'd25, 3);
    issue_item(5'd25, 5'd13, 0);
    issue_item(5'd25, 5'd26, 0);
    issue_item(5'd26, 5'd1, 0);
    issue_item(5'd31, 5'd31, 0);
    issue_item(5'd31, 5'd0, 5);
    issue_item(5'd24, 5'd31, 0);
    issue_item(5'd16, 5'd16, 0);
    issue_item(5'd10, 5'd5, 0);
    issue_item(5'd5, 5'd31, 0);
    issue_item(5'd20, 5'd0, 0);
    issue_item(5'd15, 5'd15, 0);
    issue_item(5'd1, 5'd1, 0);

    repeat (RandomItems)
      issue_random_item();

    @(negedge clk);
    start <= 1'b0;

    while (sb.pending() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d items, %0d of them out of range, %0d results checked",
             sb.requests, sb.out_of_range, sb.results);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sbn_pkg.sv
rtl/core/sbn_dpath.sv
rtl/core/sbn_ctrl.sv
rtl/core/stirling_bell_number_engine_core.sv
tb/testbench.sv
